// ===== hdl/dasf_pkg.sv =====
// Shared types and constants for the dual audio sample FIFO.
// No dependencies; used by dasf_ctrl, dasf_dpath and dual_audio_sample_fifo_unit.
package dasf_pkg;

    localparam int SAMPLE_W     = 8;
    localparam int FILL_W       = 6;
    localparam int OPCODE_W     = 2;
    localparam int TIMER_W      = 2;
    localparam int CFG_INDEX_W  = 2;
    localparam int REFILL_LEVEL = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE = 2'd0,
        OP_TIMER = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_MASTER_ENABLE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMER_SELECT_A = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMER_SELECT_B = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // load the incoming transaction into the command registers
        logic commit;   // apply the held command and load the result
    } dasf_cmd_t;

endpackage

// ===== hdl/dasf_ctrl.sv =====
// Transaction sequencer for the dual audio sample FIFO.
// Depends on dasf_pkg; drives dasf_dpath through dasf_pkg::dasf_cmd_t.
module dasf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output dasf_pkg::dasf_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   commit;

    assign s_ready     = (state_reg == ST_IDLE);
    // result slot free, or being emptied this cycle
    assign commit      = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign cmd.capture = s_valid && s_ready;
    assign cmd.commit  = commit;
    assign m_valid     = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_accept_then_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted a second transaction without a commit");

    a_valid_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(commit))
        else $error("result valid raised without a commit");

    a_hold_while_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && m_valid_reg && !m_ready) |=> (state_reg == ST_EXEC))
        else $error("commit overwrote an untaken result");

endmodule

// ===== hdl/dasf_dpath.sv =====
// Datapath of the dual audio sample FIFO: config registers, two sample stores,
// pointers, counts and output latches. Depends on dasf_pkg.
module dasf_dpath #(
    parameter int FIFO_DEPTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  dasf_pkg::dasf_cmd_t                   cmd,
    input  logic                                  cfg_wr_en,
    input  logic [dasf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic                                  cfg_wr_data,
    input  logic [dasf_pkg::OPCODE_W-1:0]         opcode,
    input  logic                                  fifo_select,
    input  logic [dasf_pkg::SAMPLE_W-1:0]         data_byte,
    input  logic [dasf_pkg::TIMER_W-1:0]          timer_number,
    output logic signed [dasf_pkg::SAMPLE_W-1:0]  sample_a,
    output logic signed [dasf_pkg::SAMPLE_W-1:0]  sample_b,
    output logic                                  refill_request_a,
    output logic                                  refill_request_b,
    output logic [dasf_pkg::FILL_W-1:0]           fill_a,
    output logic [dasf_pkg::FILL_W-1:0]           fill_b
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [dasf_pkg::OPCODE_W-1:0] op_reg;
    logic                          sel_reg;
    logic [dasf_pkg::SAMPLE_W-1:0] data_reg;
    logic [dasf_pkg::TIMER_W-1:0]  timer_reg;

    logic       master_en_reg;
    logic [1:0] tsel_reg;

    logic [1:0][dasf_pkg::SAMPLE_W-1:0] latch_reg;
    logic [1:0][CNT_W-1:0]              count_reg;
    logic [1:0]                         refill_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= opcode;
            sel_reg   <= fifo_select;
            data_reg  <= data_byte;
            timer_reg <= timer_number;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_en_reg <= 1'b0;
            tsel_reg      <= 2'b00;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dasf_pkg::CFG_MASTER_ENABLE:  master_en_reg <= cfg_wr_data;
                dasf_pkg::CFG_TIMER_SELECT_A: tsel_reg[0]   <= cfg_wr_data;
                dasf_pkg::CFG_TIMER_SELECT_B: tsel_reg[1]   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    for (genvar f = 0; f < 2; f++) begin : g_fifo
        logic [dasf_pkg::SAMPLE_W-1:0] store_mem [FIFO_DEPTH];
        logic [dasf_pkg::SAMPLE_W-1:0] rd_data_reg;
        logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
        logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
        logic [CNT_W-1:0] count_next;
        // entries [0, hwm) written since the last clear; the rest read as zero
        logic [CNT_W-1:0] hwm_reg, hwm_next;
        logic [dasf_pkg::SAMPLE_W-1:0] latch_next;
        logic refill_next;
        logic push, pop, clr, hit;

        assign push = cmd.commit && (op_reg == dasf_pkg::OP_WRITE) && (sel_reg == 1'(f))
                      && (count_reg[f] != CNT_W'(FIFO_DEPTH));
        assign pop  = cmd.commit && (op_reg == dasf_pkg::OP_TIMER) && master_en_reg
                      && (timer_reg == {1'b0, tsel_reg[f]});
        assign clr  = cmd.commit && (op_reg == dasf_pkg::OP_CLEAR) && (sel_reg == 1'(f));
        assign hit  = (CNT_W'(rd_ptr_reg) < hwm_reg);

        always_ff @(posedge aclk) begin
            if (push) begin
                store_mem[wr_ptr_reg] <= data_reg;
            end
            rd_data_reg <= store_mem[rd_ptr_reg];
        end

        always_comb begin
            rd_ptr_next = rd_ptr_reg;
            wr_ptr_next = wr_ptr_reg;
            count_next  = count_reg[f];
            hwm_next    = hwm_reg;
            latch_next  = latch_reg[f];
            refill_next = refill_reg[f];
            if (cmd.commit) begin
                refill_next = 1'b0;
            end
            if (push) begin
                wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
                count_next  = count_reg[f] + 1'b1;
                if (hwm_reg != CNT_W'(FIFO_DEPTH)) begin
                    hwm_next = hwm_reg + 1'b1;
                end
            end
            if (pop) begin
                latch_next = hit ? rd_data_reg : '0;
                if (count_reg[f] != '0) begin
                    rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                  : rd_ptr_reg + 1'b1;
                    count_next  = count_reg[f] - 1'b1;
                end
                refill_next = (32'(count_next) <= 32'(dasf_pkg::REFILL_LEVEL));
            end
            if (clr) begin
                rd_ptr_next = '0;
                wr_ptr_next = '0;
                count_next  = '0;
                hwm_next    = '0;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rd_ptr_reg    <= '0;
                wr_ptr_reg    <= '0;
                count_reg[f]  <= '0;
                hwm_reg       <= '0;
                latch_reg[f]  <= '0;
                refill_reg[f] <= 1'b0;
            end else begin
                rd_ptr_reg    <= rd_ptr_next;
                wr_ptr_reg    <= wr_ptr_next;
                count_reg[f]  <= count_next;
                hwm_reg       <= hwm_next;
                latch_reg[f]  <= latch_next;
                refill_reg[f] <= refill_next;
            end
        end

        a_count_le_hwm: assert property (@(posedge aclk) disable iff (!aresetn)
            count_reg[f] <= hwm_reg)
            else $error("held entries exceed written range");

        a_hwm_bound: assert property (@(posedge aclk) disable iff (!aresetn)
            hwm_reg <= CNT_W'(FIFO_DEPTH))
            else $error("high-water mark beyond depth");

        a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
            (count_reg[f] == '0 || count_reg[f] == CNT_W'(FIFO_DEPTH))
            |-> (rd_ptr_reg == wr_ptr_reg))
            else $error("pointers disagree with empty/full count");
    end

    assign sample_a         = $signed(latch_reg[0]);
    assign sample_b         = $signed(latch_reg[1]);
    assign refill_request_a = refill_reg[0];
    assign refill_request_b = refill_reg[1];
    assign fill_a           = dasf_pkg::FILL_W'(count_reg[0]);
    assign fill_b           = dasf_pkg::FILL_W'(count_reg[1]);

endmodule

// ===== hdl/dual_audio_sample_fifo_unit.sv =====
// Top level of the dual audio sample FIFO pair.
// Depends on dasf_pkg, dasf_ctrl and dasf_dpath.

// Two ring FIFOs (A and B) of signed 8-bit samples, FIFO_DEPTH entries each.
// Every input transaction yields exactly one result transaction carrying both
// output latches, both refill requests and both fill levels. Opcodes: write
// pushes data_byte into the selected FIFO (dropped when full); timer overflow
// pops every FIFO whose timer select matches timer_number, if master enable
// is set, and raises that FIFO's refill request when it then holds 16 or fewer
// entries; clear empties the selected FIFO and makes its store read as zero
// (its latch is kept). Popping an empty FIFO re-reads the entry at the read
// pointer. A transaction is taken while idle, as the sample store's registered
// read port fetches the entry at each read pointer, and is then committed; no
// new transaction is taken before that commit. The result sits in an output
// register; a new transaction is taken while it waits, and only the commit
// stalls until the result is taken. No clearing pass after reset or clear: a
// per-FIFO write high-water mark marks which store entries read back as zero.
// Config registers (cfg_index 0 master enable, 1 timer select A, 2 timer
// select B) must be written only while idle; the block does not enforce it.
module dual_audio_sample_fifo_unit #(
    parameter int FIFO_DEPTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [dasf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic                                  cfg_wr_data,
    // input transactions
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [dasf_pkg::OPCODE_W-1:0]         s_opcode,
    input  logic                                  s_fifo_select,
    input  logic [dasf_pkg::SAMPLE_W-1:0]         s_data_byte,
    input  logic [dasf_pkg::TIMER_W-1:0]          s_timer_number,
    // result transactions
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [dasf_pkg::SAMPLE_W-1:0]  m_sample_a,
    output logic signed [dasf_pkg::SAMPLE_W-1:0]  m_sample_b,
    output logic                                  m_refill_request_a,
    output logic                                  m_refill_request_b,
    output logic [dasf_pkg::FILL_W-1:0]           m_fill_a,
    output logic [dasf_pkg::FILL_W-1:0]           m_fill_b
);

    dasf_pkg::dasf_cmd_t cmd;

    // sequencer: accept, commit, result handshake
    dasf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // stores, pointers and latches; result fields come straight from state
    // registers that only move on a commit
    dasf_dpath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .opcode           (s_opcode),
        .fifo_select      (s_fifo_select),
        .data_byte        (s_data_byte),
        .timer_number     (s_timer_number),
        .sample_a         (m_sample_a),
        .sample_b         (m_sample_b),
        .refill_request_a (m_refill_request_a),
        .refill_request_b (m_refill_request_b),
        .fill_a           (m_fill_a),
        .fill_b           (m_fill_b)
    );

endmodule

// ===== tb/dasf_result_checker.sv =====
// Result checker for dual_audio_sample_fifo_unit: predicts each result transaction and compares.
// Depends on dasf_pkg; watches the config port and both channels of the block.
module dasf_result_checker #(
    parameter int FIFO_DEPTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [dasf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic                                  cfg_wr_data,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic [dasf_pkg::OPCODE_W-1:0]         s_opcode,
    input  logic                                  s_fifo_select,
    input  logic [dasf_pkg::SAMPLE_W-1:0]         s_data_byte,
    input  logic [dasf_pkg::TIMER_W-1:0]          s_timer_number,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic signed [dasf_pkg::SAMPLE_W-1:0]  m_sample_a,
    input  logic signed [dasf_pkg::SAMPLE_W-1:0]  m_sample_b,
    input  logic                                  m_refill_request_a,
    input  logic                                  m_refill_request_b,
    input  logic [dasf_pkg::FILL_W-1:0]           m_fill_a,
    input  logic [dasf_pkg::FILL_W-1:0]           m_fill_b,
    output int                                    mismatch_count,
    output int                                    results_pending
);

    typedef struct {
        logic signed [dasf_pkg::SAMPLE_W-1:0] sample_a;
        logic signed [dasf_pkg::SAMPLE_W-1:0] sample_b;
        logic                                 refill_a;
        logic                                 refill_b;
        logic [dasf_pkg::FILL_W-1:0]          fill_a;
        logic [dasf_pkg::FILL_W-1:0]          fill_b;
    } fifo_outputs_t;

    // shadow copy of the FIFO pair
    logic [dasf_pkg::SAMPLE_W-1:0] sample_mem [2][FIFO_DEPTH];
    int unsigned                   rd_pos [2];
    int unsigned                   wr_pos [2];
    int unsigned                   level [2];
    logic [dasf_pkg::SAMPLE_W-1:0] out_latch [2];
    logic                          sound_enable;
    logic                          timer_sel [2];

    fifo_outputs_t expected_outputs [$];
    fifo_outputs_t want;

    function automatic void empty_fifo(int f);
        for (int i = 0; i < FIFO_DEPTH; i++) sample_mem[f][i] = '0;
        rd_pos[f] = 0;
        wr_pos[f] = 0;
        level[f]  = 0;
    endfunction

    function automatic fifo_outputs_t advance_fifos(logic [dasf_pkg::OPCODE_W-1:0] op,
                                                    logic sel,
                                                    logic [dasf_pkg::SAMPLE_W-1:0] data,
                                                    logic [dasf_pkg::TIMER_W-1:0] tnum);
        fifo_outputs_t res;
        logic refill [2];
        refill[0] = 1'b0;
        refill[1] = 1'b0;
        case (op)
            dasf_pkg::OP_WRITE: begin
                // full FIFO drops the byte
                if (level[sel] < FIFO_DEPTH) begin
                    sample_mem[sel][wr_pos[sel]] = data;
                    wr_pos[sel] = (wr_pos[sel] + 1) % FIFO_DEPTH;
                    level[sel]++;
                end
            end
            dasf_pkg::OP_TIMER: begin
                if (sound_enable) begin
                    for (int f = 0; f < 2; f++) begin
                        if ({1'b0, timer_sel[f]} == tnum) begin
                            // empty pop re-reads the read position without advancing
                            out_latch[f] = sample_mem[f][rd_pos[f]];
                            if (level[f] > 0) begin
                                rd_pos[f] = (rd_pos[f] + 1) % FIFO_DEPTH;
                                level[f]--;
                            end
                            refill[f] = (level[f] <= dasf_pkg::REFILL_LEVEL);
                        end
                    end
                end
            end
            dasf_pkg::OP_CLEAR: empty_fifo(sel);
            default: ;
        endcase
        res.sample_a = out_latch[0];
        res.sample_b = out_latch[1];
        res.refill_a = refill[0];
        res.refill_b = refill[1];
        res.fill_a   = dasf_pkg::FILL_W'(level[0]);
        res.fill_b   = dasf_pkg::FILL_W'(level[1]);
        return res;
    endfunction

    task automatic check_field(string field, logic signed [31:0] exp_v, logic signed [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", field, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            empty_fifo(0);
            empty_fifo(1);
            out_latch[0]   = '0;
            out_latch[1]   = '0;
            sound_enable   = 1'b0;
            timer_sel[0]   = 1'b0;
            timer_sel[1]   = 1'b0;
            mismatch_count = 0;
            expected_outputs.delete();
        end else begin
            // compare before predicting: a result never belongs to a transaction of the same edge
            if (m_valid && m_ready) begin
                if (expected_outputs.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    mismatch_count++;
                end else begin
                    want = expected_outputs.pop_front();
                    check_field("sample_a", want.sample_a, m_sample_a);
                    check_field("sample_b", want.sample_b, m_sample_b);
                    check_field("refill_request_a", want.refill_a, m_refill_request_a);
                    check_field("refill_request_b", want.refill_b, m_refill_request_b);
                    check_field("fill_a", want.fill_a, m_fill_a);
                    check_field("fill_b", want.fill_b, m_fill_b);
                end
            end
            if (s_valid && s_ready)
                expected_outputs.push_back(advance_fifos(s_opcode, s_fifo_select,
                                                         s_data_byte, s_timer_number));
            if (cfg_wr_en) begin
                case (cfg_index)
                    dasf_pkg::CFG_MASTER_ENABLE:  sound_enable = cfg_wr_data;
                    dasf_pkg::CFG_TIMER_SELECT_A: timer_sel[0] = cfg_wr_data;
                    dasf_pkg::CFG_TIMER_SELECT_B: timer_sel[1] = cfg_wr_data;
                    default: ;
                endcase
            end
        end
        results_pending <= expected_outputs.size();
    end

endmodule

// ===== tb/dual_audio_sample_fifo_unit_test.sv =====
// Testbench top for dual_audio_sample_fifo_unit: clock, reset, stimulus and verdict.
// Depends on dasf_pkg, dasf_result_checker and the RTL of the block.
module dual_audio_sample_fifo_unit_test;

    localparam int FIFO_DEPTH    = 32;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int IDLE_PCT      = 16;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 200000; // far above the slowest clean run
    // opcode three has no package name; the block treats it as a no-op apart from clearing the refill requests
    localparam logic [dasf_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // mixes of operations used by the random phases
    localparam int MIX_FILL    = 0;
    localparam int MIX_DRAIN   = 1;
    localparam int MIX_BALANCE = 2;

    logic                                  aclk = 1'b0;
    logic                                  aresetn = 1'b0;
    logic                                  cfg_wr_en = 1'b0;
    logic [dasf_pkg::CFG_INDEX_W-1:0]      cfg_index = dasf_pkg::CFG_MASTER_ENABLE;
    logic                                  cfg_wr_data = 1'b0;
    logic                                  s_valid = 1'b0;
    logic                                  s_ready;
    logic [dasf_pkg::OPCODE_W-1:0]         s_opcode = dasf_pkg::OP_WRITE;
    logic                                  s_fifo_select = 1'b0;
    logic [dasf_pkg::SAMPLE_W-1:0]         s_data_byte = '0;
    logic [dasf_pkg::TIMER_W-1:0]          s_timer_number = '0;
    logic                                  m_valid;
    logic                                  m_ready = 1'b0;
    logic signed [dasf_pkg::SAMPLE_W-1:0]  m_sample_a;
    logic signed [dasf_pkg::SAMPLE_W-1:0]  m_sample_b;
    logic                                  m_refill_request_a;
    logic                                  m_refill_request_b;
    logic [dasf_pkg::FILL_W-1:0]           m_fill_a;
    logic [dasf_pkg::FILL_W-1:0]           m_fill_b;

    int   mismatch_count;
    int   results_pending;
    logic steady = 1'b0;   // when high neither side idles
    int   cycle_count = 0;

    always #5 aclk = ~aclk;

    dual_audio_sample_fifo_unit #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_fifo_select     (s_fifo_select),
        .s_data_byte       (s_data_byte),
        .s_timer_number    (s_timer_number),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sample_a        (m_sample_a),
        .m_sample_b        (m_sample_b),
        .m_refill_request_a(m_refill_request_a),
        .m_refill_request_b(m_refill_request_b),
        .m_fill_a          (m_fill_a),
        .m_fill_b          (m_fill_b)
    );

    // Checker sits beside the block on the same wires; it owns all prediction.
    dasf_result_checker #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) i_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_fifo_select     (s_fifo_select),
        .s_data_byte       (s_data_byte),
        .s_timer_number    (s_timer_number),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sample_a        (m_sample_a),
        .m_sample_b        (m_sample_b),
        .m_refill_request_a(m_refill_request_a),
        .m_refill_request_b(m_refill_request_b),
        .m_fill_a          (m_fill_a),
        .m_fill_b          (m_fill_b),
        .mismatch_count    (mismatch_count),
        .results_pending   (results_pending)
    );

    // Receiver back-pressure: ~16% of cycles stalled unless in a steady stretch.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // One input transaction. Optional idle cycles go before valid rises; once raised,
    // valid and payload hold until the edge where s_ready is seen high.
    task automatic send_item(logic [dasf_pkg::OPCODE_W-1:0] op, logic sel,
                             logic [dasf_pkg::SAMPLE_W-1:0] data,
                             logic [dasf_pkg::TIMER_W-1:0] tnum);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_fifo_select  <= sel;
        s_data_byte    <= data;
        s_timer_number <= tnum;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending and wait until every expected result has come back, then let the
    // pipeline go quiet. The first edge lets the checker count the last transaction.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // All three sound registers, one per cycle; only called while the block is idle.
    task automatic write_sound_regs(logic enable, logic sel_a, logic sel_b);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= dasf_pkg::CFG_MASTER_ENABLE;
        cfg_wr_data <= enable;
        @(posedge aclk);
        cfg_index   <= dasf_pkg::CFG_TIMER_SELECT_A;
        cfg_wr_data <= sel_a;
        @(posedge aclk);
        cfg_index   <= dasf_pkg::CFG_TIMER_SELECT_B;
        cfg_wr_data <= sel_b;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int sent;
        int phase;
        int phase_len;
        int mix;
        int r;
        logic [dasf_pkg::OPCODE_W-1:0] op;
        logic [dasf_pkg::TIMER_W-1:0]  tnum;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed part ---
        // reset settings: master enable off, so timer overflow is ignored
        send_item(dasf_pkg::OP_TIMER, 1'b0, 8'h00, 2'd0);
        send_item(dasf_pkg::OP_WRITE, 1'b0, 8'h80, 2'd0);
        send_item(OP_UNUSED, 1'b1, 8'hFF, 2'd3);
        settle();

        // A on timer 0, B on timer 1
        write_sound_regs(1'b1, 1'b0, 1'b1);
        send_item(dasf_pkg::OP_TIMER, 1'b0, 8'h00, 2'd0);   // pops -128 from A, refill raised
        send_item(dasf_pkg::OP_TIMER, 1'b1, 8'hFF, 2'd0);   // A empty: re-read, no advance
        send_item(dasf_pkg::OP_WRITE, 1'b0, 8'h7F, 2'd1);
        send_item(dasf_pkg::OP_WRITE, 1'b1, 8'h00, 2'd2);
        send_item(dasf_pkg::OP_WRITE, 1'b1, 8'hFF, 2'd3);
        send_item(dasf_pkg::OP_WRITE, 1'b1, 8'h55, 2'd0);
        send_item(dasf_pkg::OP_TIMER, 1'b0, 8'h00, 2'd1);   // pops B only
        send_item(dasf_pkg::OP_TIMER, 1'b0, 8'h00, 2'd2);   // timers 2 and 3 match nothing
        send_item(dasf_pkg::OP_TIMER, 1'b1, 8'hFF, 2'd3);
        send_item(dasf_pkg::OP_CLEAR, 1'b1, 8'h00, 2'd0);   // B emptied, latch B kept
        send_item(dasf_pkg::OP_TIMER, 1'b0, 8'h00, 2'd1);   // empty B after clear reads zero
        send_item(dasf_pkg::OP_WRITE, 1'b0, 8'hAA, 2'd0);
        settle();

        // both FIFOs on timer 1: one overflow pops both
        write_sound_regs(1'b1, 1'b1, 1'b1);
        send_item(dasf_pkg::OP_TIMER, 1'b0, 8'h00, 2'd1);
        send_item(dasf_pkg::OP_TIMER, 1'b1, 8'h00, 2'd0);
        send_item(dasf_pkg::OP_CLEAR, 1'b0, 8'hFF, 2'd3);
        send_item(OP_UNUSED, 1'b0, 8'h00, 2'd0);
        settle();

        write_sound_regs(1'b0, 1'b1, 1'b0);
        send_item(dasf_pkg::OP_TIMER, 1'b1, 8'h00, 2'd1);
        send_item(dasf_pkg::OP_WRITE, 1'b0, 8'h01, 2'd1);
        settle();

        // --- random part ---
        // Phase 0 fills (reaches full and dropped writes), phase 1 drains (reaches empty
        // pops and refill requests), later ones pick either or a balanced mix at random.
        // Each phase ends by waiting for every result before the sound registers change.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            // registers: all bit combinations; enable mostly on so pops happen
            write_sound_regs($urandom_range(3) != 0, 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            steady    <= (phase == 2 || phase == 3);
            mix       = (phase < 2) ? phase : $urandom_range(2);
            phase_len = $urandom_range(40, 120);
            if (phase_len > RANDOM_ITEMS - sent)
                phase_len = RANDOM_ITEMS - sent;
            for (int i = 0; i < phase_len; i++) begin
                r = $urandom_range(99);
                case (mix)
                    MIX_FILL:
                        op = (r < 85) ? dasf_pkg::OP_WRITE : (r < 97) ? dasf_pkg::OP_TIMER :
                             (r < 98) ? dasf_pkg::OP_CLEAR : OP_UNUSED;
                    MIX_DRAIN:
                        op = (r < 20) ? dasf_pkg::OP_WRITE : (r < 95) ? dasf_pkg::OP_TIMER :
                             (r < 97) ? dasf_pkg::OP_CLEAR : OP_UNUSED;
                    default:
                        op = (r < 45) ? dasf_pkg::OP_WRITE : (r < 90) ? dasf_pkg::OP_TIMER :
                             (r < 96) ? dasf_pkg::OP_CLEAR : OP_UNUSED;
                endcase
                // timers 0 and 1 mostly; 2 and 3 now and then
                tnum = ($urandom_range(9) < 8) ? dasf_pkg::TIMER_W'($urandom_range(1))
                                               : dasf_pkg::TIMER_W'($urandom_range(3));
                send_item(op, 1'($urandom_range(1)),
                          dasf_pkg::SAMPLE_W'($urandom_range(255)), tnum);
            end
            sent += phase_len;
            phase++;
            settle();
        end

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
